### design/btcu_pkg.sv
`default_nettype none
package btcu_pkg;

  localparam int COORD_BITS = 10;
  localparam int TEX_BITS   = 10;
  localparam int SIZE_BITS  = TEX_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS + 2;
  localparam int AREA_BITS  = 2 * COORD_BITS + 1;
  localparam int QUO_BITS   = SIZE_BITS;
  localparam int NUM_BITS   = AREA_BITS + SIZE_BITS;
  localparam int DIV_STAGES = (QUO_BITS + 1) / 2;
  localparam int NUM_PROD   = 12;
  localparam int IDX_BITS   = 3;

  localparam logic [TEX_BITS-1:0] TEXEL_MAX = {TEX_BITS{1'b1}};

  typedef enum logic [IDX_BITS-1:0] {
    REG_A_X  = 3'd0,
    REG_A_Y  = 3'd1,
    REG_B_X  = 3'd2,
    REG_B_Y  = 3'd3,
    REG_C_X  = 3'd4,
    REG_C_Y  = 3'd5,
    REG_TEX_W = 3'd6,
    REG_TEX_H = 3'd7
  } reg_idx_t;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [AREA_BITS-1:0]        area_t;

  // payload that rides beside the dividers
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   covered;
    logic   t_zero;
  } side_t;

  // x * (y1 - y2) with x unsigned
  function automatic prod_t cross_term(input coord_t x, input coord_t y1, input coord_t y2);
    logic signed [COORD_BITS:0] xs;
    logic signed [COORD_BITS:0] d;
    xs = signed'({1'b0, x});
    d  = signed'({1'b0, y1}) - signed'({1'b0, y2});
    return PROD_BITS'(xs * d);
  endfunction

  function automatic area_t abs_sum(input prod_t p0, input prod_t p1, input prod_t p2);
    logic signed [PROD_BITS+1:0] s;
    s = (PROD_BITS+2)'(p0) + (PROD_BITS+2)'(p1) + (PROD_BITS+2)'(p2);
    if (s < 0) begin
      s = -s;
    end
    return s[AREA_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

### design/btcu_ifs.sv
`default_nettype none
interface btcu_in_if import btcu_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface btcu_out_if import btcu_pkg::*; ();
  logic                valid;
  logic                ready;
  coord_t              out_x;
  coord_t              out_y;
  logic                covered;
  logic [TEX_BITS-1:0] texel_x;
  logic [TEX_BITS-1:0] texel_y;
  modport source (output valid, out_x, out_y, covered, texel_x, texel_y, input ready);
  modport sink   (input valid, out_x, out_y, covered, texel_x, texel_y, output ready);
endinterface

interface btcu_cfg_if import btcu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_BITS-1:0]  index;
  logic [SIZE_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/barycentric_texture_coord_unit_core.sv
// channel  dir  handshake    payload
// in_chan  in   valid/ready  pixel_x, pixel_y
// out_chan out  valid/ready  out_x, out_y, covered, texel_x, texel_y
// cfg_chan in   valid/ready  index, data (always ready)
//
// one pixel per cycle unless the pipe holds
// two pipelined restoring dividers, two quotient bits per stage
// stages: cross products, areas, coverage and numerators, divider, output register
// the whole pipe holds when the output register is full and not taken
// rst_n is synchronous; it clears valid bits and loads the reset triangle and texture size
`default_nettype none
module barycentric_texture_coord_unit_core import btcu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  btcu_in_if.sink      in_chan,
  btcu_out_if.source   out_chan,
  btcu_cfg_if.sink     cfg_chan
);

  coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [SIZE_BITS-1:0] tw_r, th_r;

  logic adv;

  logic   s1_valid_r;
  coord_t s1_px_r, s1_py_r;
  prod_t  prod_r [NUM_PROD];
  prod_t  prod_nxt [NUM_PROD];

  logic   s2_valid_r;
  coord_t s2_px_r, s2_py_r;
  area_t  t_r, sa_r, sb_r, sc_r;

  logic                s3_valid_r;
  side_t               s3_side_r;
  logic [NUM_BITS-1:0] numx_r, numy_r;
  area_t               den_r;
  logic [TEX_BITS-1:0] limx_r, limy_r;
  logic [AREA_BITS+1:0] sum_nxt;
  logic [SIZE_BITS-1:0] szw, szh;
  logic [SIZE_BITS-1:0] szw_m1, szh_m1;

  logic  dv_r   [DIV_STAGES];
  side_t side_r [DIV_STAGES];
  logic [TEX_BITS-1:0] qx, qy;

  logic                out_valid_r;
  side_t               out_side_r;
  logic [TEX_BITS-1:0] out_tx_r, out_ty_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= COORD_BITS'(100);
      ay_r <= COORD_BITS'(100);
      bx_r <= COORD_BITS'(200);
      by_r <= COORD_BITS'(300);
      cx_r <= COORD_BITS'(300);
      cy_r <= COORD_BITS'(100);
      tw_r <= SIZE_BITS'(256);
      th_r <= SIZE_BITS'(256);
    end else if (cfg_chan.valid) begin
      case (reg_idx_t'(cfg_chan.index))
        REG_A_X:   ax_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_A_Y:   ay_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_B_X:   bx_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_B_Y:   by_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_C_X:   cx_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_C_Y:   cy_r <= cfg_chan.data[COORD_BITS-1:0];
        REG_TEX_W: tw_r <= cfg_chan.data;
        REG_TEX_H: th_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // stage 1: cross products
  always_comb begin
    prod_nxt[0]  = cross_term(ax_r, by_r, cy_r);
    prod_nxt[1]  = cross_term(bx_r, cy_r, ay_r);
    prod_nxt[2]  = cross_term(cx_r, ay_r, by_r);
    prod_nxt[3]  = cross_term(in_chan.pixel_x, by_r, cy_r);
    prod_nxt[4]  = cross_term(bx_r, cy_r, in_chan.pixel_y);
    prod_nxt[5]  = cross_term(cx_r, in_chan.pixel_y, by_r);
    prod_nxt[6]  = cross_term(ax_r, in_chan.pixel_y, cy_r);
    prod_nxt[7]  = cross_term(in_chan.pixel_x, cy_r, ay_r);
    prod_nxt[8]  = cross_term(cx_r, ay_r, in_chan.pixel_y);
    prod_nxt[9]  = cross_term(ax_r, by_r, in_chan.pixel_y);
    prod_nxt[10] = cross_term(bx_r, in_chan.pixel_y, ay_r);
    prod_nxt[11] = cross_term(in_chan.pixel_x, ay_r, by_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r <= in_chan.pixel_x;
      s1_py_r <= in_chan.pixel_y;
      for (int i = 0; i < NUM_PROD; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // stage 2: absolute twice-areas
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px_r <= s1_px_r;
      s2_py_r <= s1_py_r;
      t_r  <= abs_sum(prod_r[0], prod_r[1], prod_r[2]);
      sa_r <= abs_sum(prod_r[3], prod_r[4], prod_r[5]);
      sb_r <= abs_sum(prod_r[6], prod_r[7], prod_r[8]);
      sc_r <= abs_sum(prod_r[9], prod_r[10], prod_r[11]);
    end
  end

  // stage 3: coverage, limits and dividends
  assign sum_nxt = (AREA_BITS+2)'(sa_r) + (AREA_BITS+2)'(sb_r) + (AREA_BITS+2)'(sc_r);
  assign szw     = (tw_r == '0) ? SIZE_BITS'(1) : tw_r;
  assign szh     = (th_r == '0) ? SIZE_BITS'(1) : th_r;
  assign szw_m1  = szw - SIZE_BITS'(1);
  assign szh_m1  = szh - SIZE_BITS'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r.px      <= s2_px_r;
      s3_side_r.py      <= s2_py_r;
      s3_side_r.t_zero  <= (t_r == '0);
      s3_side_r.covered <= (t_r != '0) && (sum_nxt == (AREA_BITS+2)'(t_r));
      numx_r <= NUM_BITS'(sa_r) * NUM_BITS'(szw);
      numy_r <= NUM_BITS'(sb_r) * NUM_BITS'(szh);
      den_r  <= t_r;
      limx_r <= (szw_m1 > SIZE_BITS'(TEXEL_MAX)) ? TEXEL_MAX : szw_m1[TEX_BITS-1:0];
      limy_r <= (szh_m1 > SIZE_BITS'(TEXEL_MAX)) ? TEXEL_MAX : szh_m1[TEX_BITS-1:0];
    end
  end

  btcu_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (numx_r),
    .den (den_r),
    .lim (limx_r),
    .quo (qx)
  );

  btcu_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (numy_r),
    .den (den_r),
    .lim (limy_r),
    .quo (qy)
  );

  // side payload delay matching the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s3_side_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r  <= in_chan.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      dv_r[0]     <= s3_valid_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      out_valid_r <= dv_r[DIV_STAGES-1];
    end
  end

  // output register; degenerate triangle forces texel zero
  always_ff @(posedge clk) begin
    if (adv) begin
      out_side_r <= side_r[DIV_STAGES-1];
      out_tx_r   <= side_r[DIV_STAGES-1].t_zero ? '0 : qx;
      out_ty_r   <= side_r[DIV_STAGES-1].t_zero ? '0 : qy;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.out_x   = out_side_r.px;
  assign out_chan.out_y   = out_side_r.py;
  assign out_chan.covered = out_side_r.covered;
  assign out_chan.texel_x = out_tx_r;
  assign out_chan.texel_y = out_ty_r;

endmodule
`default_nettype wire

### design/btcu_div.sv
`default_nettype none
module btcu_div import btcu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire area_t               den,
  input  wire logic [TEX_BITS-1:0] lim,
  output logic [TEX_BITS-1:0]      quo
);

  logic [NUM_BITS-1:0] rem_r [DIV_STAGES];
  logic [QUO_BITS-1:0] q_r   [DIV_STAGES];
  area_t               den_r [DIV_STAGES];
  logic [TEX_BITS-1:0] lim_r [DIV_STAGES];
  logic                ovf_r [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [NUM_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0] q_in;
      area_t               den_in;
      logic [TEX_BITS-1:0] lim_in;
      logic                ovf_in;
      logic [NUM_BITS-1:0] rem_nxt;
      logic [QUO_BITS-1:0] q_nxt;

      if (k == 0) begin : g_first
        assign rem_in = num;
        assign q_in   = '0;
        assign den_in = den;
        assign lim_in = lim;
        // quotient too big for the quotient bits: saturate later
        assign ovf_in = (NUM_BITS+1)'(num) >= (NUM_BITS+1)'({den, {QUO_BITS{1'b0}}});
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign q_in   = q_r[k-1];
        assign den_in = den_r[k-1];
        assign lim_in = lim_r[k-1];
        assign ovf_in = ovf_r[k-1];
      end

      // two restoring steps per stage, top bit first
      always_comb begin
        logic [NUM_BITS-1:0] sub;
        rem_nxt = rem_in;
        q_nxt   = q_in;
        for (int j = 2 * k; j < 2 * k + 2; j++) begin
          if (j < QUO_BITS) begin
            sub = NUM_BITS'(den_in) << (QUO_BITS - 1 - j);
            if (rem_nxt >= sub) begin
              rem_nxt = rem_nxt - sub;
              q_nxt[QUO_BITS-1-j] = 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          q_r[k]   <= q_nxt;
          den_r[k] <= den_in;
          lim_r[k] <= lim_in;
          ovf_r[k] <= ovf_in;
        end
      end
    end
  endgenerate

  always_comb begin
    if (ovf_r[DIV_STAGES-1] ||
        q_r[DIV_STAGES-1] > QUO_BITS'(lim_r[DIV_STAGES-1])) begin
      quo = lim_r[DIV_STAGES-1];
    end else begin
      quo = q_r[DIV_STAGES-1][TEX_BITS-1:0];
    end
  end

endmodule
`default_nettype wire
